[rtl/ckx_pkg.sv]
// Shared types, constants and quarter-round helper for the ChaCha keystream xor block.
// Used by ckx_ctrl, ckx_dp and chacha_keystream_xor_top; depends on nothing else.
`default_nettype none

package ckx_pkg;

    localparam int REFILL_BLOCKS   = 4;
    localparam int WORDS_PER_BLOCK = 8;
    localparam int BUF_DEPTH       = 32;
    localparam int ADDR_W          = 5;
    localparam int BLK_W           = 2;
    localparam int WORD_W          = 3;
    localparam int LEFT_W          = 6;
    localparam int STEP_W          = 7;
    localparam int DBL_W           = 5;
    localparam int TDATA_W         = 72;

    localparam logic [LEFT_W-1:0] TOTAL_WORDS = LEFT_W'(REFILL_BLOCKS * WORDS_PER_BLOCK);
    localparam logic [BLK_W-1:0]  LAST_BLK    = BLK_W'(REFILL_BLOCKS - 1);
    localparam logic [63:0]       CTR_STEP    = 64'(REFILL_BLOCKS);

    localparam logic [2:0] CFG_CONST_LO = 3'd0;
    localparam logic [2:0] CFG_CONST_HI = 3'd1;
    localparam logic [2:0] CFG_KEY_0    = 3'd2;
    localparam logic [2:0] CFG_KEY_1    = 3'd3;
    localparam logic [2:0] CFG_KEY_2    = 3'd4;
    localparam logic [2:0] CFG_KEY_3    = 3'd5;
    localparam logic [2:0] CFG_NONCE    = 3'd6;
    localparam logic [2:0] CFG_ROUNDS   = 3'd7;

    localparam logic KIND_MSG     = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic [4:0] ROUNDS_RESET = 5'd20;

    typedef struct packed {
        logic              take_item;
        logic              restart;
        logic              load_state;
        logic              round_step;
        logic              diag;
        logic              half;
        logic              ffwd;
        logic [BLK_W-1:0]  blk;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_word;
        logic              ctr_advance;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              out_load;
        logic [WORD_W-1:0] out_word;
    } t_cmd;

    typedef struct packed {
        logic             out_busy;
        logic [DBL_W-1:0] dbl_rounds;
    } t_sts;

    // Half a quarter round: rotations 16/12 when half is low, 8/7 when high.
    // Result packed as {d, c, b, a}.
    function automatic logic [127:0] qr_half(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d,
                                             input logic half);
        logic [31:0] a1;
        logic [31:0] b1;
        logic [31:0] c1;
        logic [31:0] d1;
        logic [31:0] t;
        a1 = a + b;
        t  = d ^ a1;
        d1 = half ? {t[23:0], t[31:24]} : {t[15:0], t[31:16]};
        c1 = c + d1;
        t  = b ^ c1;
        b1 = half ? {t[24:0], t[31:25]} : {t[19:0], t[31:20]};
        return {d1, c1, b1, a1};
    endfunction

endpackage

`default_nettype wire

[rtl/ckx_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependencies.
`default_nettype none

module ckx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/ckx_ctrl.sv]
// Controller: item handshake, refill sequencing (rounds, feed-forward, buffer drain)
// and buffer read pointer. Depends on ckx_pkg.
`default_nettype none

module ckx_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_kind,
    output logic               o_in_ready,
    input  wire ckx_pkg::t_sts i_sts,
    output ckx_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FFWD,
        ST_FINISH,
        ST_READ
    } t_state;

    t_state                              r_state;
    logic [ckx_pkg::STEP_W-1:0]          r_step;
    logic [ckx_pkg::BLK_W-1:0]           r_blk;
    logic                                r_drain;
    logic [ckx_pkg::WORD_W-1:0]          r_drain_cnt;
    logic [ckx_pkg::BLK_W-1:0]           r_drain_blk;
    logic [ckx_pkg::LEFT_W-1:0]          r_words_left;
    logic [ckx_pkg::ADDR_W-1:0]          r_pos;

    logic                                accept;
    logic [ckx_pkg::LEFT_W-1:0]          pos_full;
    logic [ckx_pkg::ADDR_W-1:0]          pos_now;
    logic [ckx_pkg::STEP_W-1:0]          last_step;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid & o_in_ready;
    assign pos_full   = ckx_pkg::TOTAL_WORDS - r_words_left;
    assign pos_now    = pos_full[ckx_pkg::ADDR_W-1:0];
    assign last_step  = {i_sts.dbl_rounds, 2'b00} - ckx_pkg::STEP_W'(1);

    always_comb begin
        o_cmd          = '0;
        o_cmd.blk      = r_blk;
        o_cmd.diag     = r_step[1];
        o_cmd.half     = r_step[0];
        o_cmd.wr_en    = r_drain;
        o_cmd.wr_addr  = {r_drain_blk, r_drain_cnt};
        o_cmd.wr_word  = r_drain_cnt;
        o_cmd.out_word = r_pos[ckx_pkg::WORD_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_kind == ckx_pkg::KIND_RESTART) begin
                        o_cmd.restart = 1'b1;
                    end else begin
                        o_cmd.take_item = 1'b1;
                        if (r_words_left != '0) begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_addr = pos_now;
                        end
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load_state = 1'b1;
            end
            ST_ROUND: begin
                o_cmd.round_step = 1'b1;
            end
            ST_FFWD: begin
                o_cmd.ffwd = ~r_drain;
            end
            ST_FINISH: begin
                if (!r_drain) begin
                    o_cmd.ctr_advance = 1'b1;
                    o_cmd.rd_en       = 1'b1;
                    o_cmd.rd_addr     = '0;
                end
            end
            ST_READ: begin
                o_cmd.out_load = ~i_sts.out_busy;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= '0;
            r_blk        <= '0;
            r_drain      <= 1'b0;
            r_drain_cnt  <= '0;
            r_drain_blk  <= '0;
            r_words_left <= '0;
            r_pos        <= '0;
        end else begin
            if (r_drain) begin
                r_drain_cnt <= r_drain_cnt + ckx_pkg::WORD_W'(1);
                if (r_drain_cnt == '1) begin
                    r_drain <= 1'b0;
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_in_kind == ckx_pkg::KIND_RESTART) begin
                            r_words_left <= '0;
                        end else if (r_words_left != '0) begin
                            r_pos        <= pos_now;
                            r_words_left <= r_words_left - ckx_pkg::LEFT_W'(1);
                            r_state      <= ST_READ;
                        end else begin
                            r_blk   <= '0;
                            r_state <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    r_step  <= '0;
                    r_state <= (i_sts.dbl_rounds == '0) ? ST_FFWD : ST_ROUND;
                end
                ST_ROUND: begin
                    if (r_step == last_step) begin
                        r_state <= ST_FFWD;
                    end else begin
                        r_step <= r_step + ckx_pkg::STEP_W'(1);
                    end
                end
                ST_FFWD: begin
                    if (!r_drain) begin
                        r_drain     <= 1'b1;
                        r_drain_cnt <= '0;
                        r_drain_blk <= r_blk;
                        if (r_blk == ckx_pkg::LAST_BLK) begin
                            r_state <= ST_FINISH;
                        end else begin
                            r_blk   <= r_blk + ckx_pkg::BLK_W'(1);
                            r_state <= ST_LOAD;
                        end
                    end
                end
                ST_FINISH: begin
                    if (!r_drain) begin
                        r_pos        <= '0;
                        r_words_left <= ckx_pkg::TOTAL_WORDS - ckx_pkg::LEFT_W'(1);
                        r_state      <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (!i_sts.out_busy) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/ckx_dp.sv]
// Datapath: configuration registers, block counter, ChaCha working state with one
// half-quarter-round step per cycle, feed-forward hold bank, keystream RAM, output register.
// Depends on ckx_pkg and ckx_ram.
`default_nettype none

module ckx_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [2:0]                  i_cfg_idx,
    input  wire logic [63:0]                 i_cfg_data,
    input  wire logic [63:0]                 i_data_in,
    input  wire logic                        i_xor_enable,
    input  wire logic                        i_out_ready,
    input  wire ckx_pkg::t_cmd               i_cmd,
    output ckx_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    output logic [63:0]                      o_data_out,
    output logic [ckx_pkg::WORD_W-1:0]       o_word_in_block
);

    logic [63:0] r_const_lo;
    logic [63:0] r_const_hi;
    logic [63:0] r_key_0;
    logic [63:0] r_key_1;
    logic [63:0] r_key_2;
    logic [63:0] r_key_3;
    logic [63:0] r_nonce;
    logic [4:0]  r_rounds;
    logic [63:0] r_ctr;

    logic [31:0] r_x    [16];
    logic [31:0] r_hold [16];
    logic [31:0] in_st  [16];
    logic [31:0] x_col  [16];
    logic [31:0] x_dia  [16];
    logic [127:0] q_col [4];
    logic [127:0] q_dia [4];

    logic [63:0] r_item_data;
    logic        r_item_xor;
    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic [ckx_pkg::WORD_W-1:0] r_out_word;

    logic [63:0] blk_ctr;
    logic [5:0]  rounds_up;
    logic [63:0] wr_data;
    logic [63:0] ks;

    assign blk_ctr   = r_ctr + 64'(i_cmd.blk);
    assign rounds_up = {1'b0, r_rounds} + 6'd1;

    always_comb begin
        in_st[0]  = r_const_lo[31:0];
        in_st[1]  = r_const_lo[63:32];
        in_st[2]  = r_const_hi[31:0];
        in_st[3]  = r_const_hi[63:32];
        in_st[4]  = r_key_0[31:0];
        in_st[5]  = r_key_0[63:32];
        in_st[6]  = r_key_1[31:0];
        in_st[7]  = r_key_1[63:32];
        in_st[8]  = r_key_2[31:0];
        in_st[9]  = r_key_2[63:32];
        in_st[10] = r_key_3[31:0];
        in_st[11] = r_key_3[63:32];
        in_st[12] = blk_ctr[31:0];
        in_st[13] = blk_ctr[63:32];
        in_st[14] = r_nonce[31:0];
        in_st[15] = r_nonce[63:32];
    end

    always_comb begin
        for (int q = 0; q < 4; q++) begin
            q_col[q] = ckx_pkg::qr_half(r_x[q], r_x[4 + q], r_x[8 + q], r_x[12 + q],
                                        i_cmd.half);
            q_dia[q] = ckx_pkg::qr_half(r_x[q], r_x[4 + ((q + 1) & 3)],
                                        r_x[8 + ((q + 2) & 3)], r_x[12 + ((q + 3) & 3)],
                                        i_cmd.half);
        end
        for (int k = 0; k < 16; k++) begin
            x_col[k] = r_x[k];
            x_dia[k] = r_x[k];
        end
        for (int q = 0; q < 4; q++) begin
            x_col[q]                  = q_col[q][31:0];
            x_col[4 + q]              = q_col[q][63:32];
            x_col[8 + q]              = q_col[q][95:64];
            x_col[12 + q]             = q_col[q][127:96];
            x_dia[q]                  = q_dia[q][31:0];
            x_dia[4 + ((q + 1) & 3)]  = q_dia[q][63:32];
            x_dia[8 + ((q + 2) & 3)]  = q_dia[q][95:64];
            x_dia[12 + ((q + 3) & 3)] = q_dia[q][127:96];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_const_lo <= '0;
            r_const_hi <= '0;
            r_key_0    <= '0;
            r_key_1    <= '0;
            r_key_2    <= '0;
            r_key_3    <= '0;
            r_nonce    <= '0;
            r_rounds   <= ckx_pkg::ROUNDS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ckx_pkg::CFG_CONST_LO: r_const_lo <= i_cfg_data;
                ckx_pkg::CFG_CONST_HI: r_const_hi <= i_cfg_data;
                ckx_pkg::CFG_KEY_0:    r_key_0    <= i_cfg_data;
                ckx_pkg::CFG_KEY_1:    r_key_1    <= i_cfg_data;
                ckx_pkg::CFG_KEY_2:    r_key_2    <= i_cfg_data;
                ckx_pkg::CFG_KEY_3:    r_key_3    <= i_cfg_data;
                ckx_pkg::CFG_NONCE:    r_nonce    <= i_cfg_data;
                ckx_pkg::CFG_ROUNDS:   r_rounds   <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
        end else if (i_cmd.restart) begin
            r_ctr <= i_data_in;
        end else if (i_cmd.ctr_advance) begin
            r_ctr <= r_ctr + ckx_pkg::CTR_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_state) begin
            r_x <= in_st;
        end else if (i_cmd.round_step) begin
            r_x <= i_cmd.diag ? x_dia : x_col;
        end
        if (i_cmd.ffwd) begin
            for (int k = 0; k < 16; k++) begin
                r_hold[k] <= r_x[k] + in_st[k];
            end
        end
        if (i_cmd.take_item) begin
            r_item_data <= i_data_in;
            r_item_xor  <= i_xor_enable;
        end
    end

    assign wr_data = {r_hold[{i_cmd.wr_word, 1'b1}], r_hold[{i_cmd.wr_word, 1'b0}]};

    ckx_ram #(
        .WIDTH (64),
        .DEPTH (ckx_pkg::BUF_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (i_cmd.wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (ks)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_item_xor ? (r_item_data ^ ks) : ks;
            r_out_word <= i_cmd.out_word;
        end
    end

    assign o_sts.out_busy   = r_out_valid & ~i_out_ready;
    assign o_sts.dbl_rounds = rounds_up[5:1];
    assign o_out_valid      = r_out_valid;
    assign o_data_out       = r_out_data;
    assign o_word_in_block  = r_out_word;

endmodule

`default_nettype wire

[rtl/chacha_keystream_xor_top.sv]
// A buffered word is read from the keystream RAM and then loaded into the output register,
// which holds while the output stalls. A refill runs load, rounds (rounds rounded up to even,
// one half quarter round per cycle), feed-forward and buffer drain for each of 4 blocks.
// A message beat blocks new beats until its word is loaded for output; one refill per 32 words. Restart: no output.
// Reset (synchronous, active low) clears the registers to their defaults, the counter to
// zero and empties the buffer. Top level; depends on ckx_pkg, ckx_ctrl, ckx_dp.
`default_nettype none

module chacha_keystream_xor_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [ckx_pkg::TDATA_W-1:0] s_axis_tdata,  // data_in[63:0], xor_enable[64]
    input  wire logic        s_axis_tuser,                  // kind[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [ckx_pkg::TDATA_W-1:0] m_axis_tdata       // data_out[63:0], word_in_block[66:64]
);

    ckx_pkg::t_cmd               cmd;
    ckx_pkg::t_sts               sts;
    logic [63:0]                 data_out;
    logic [ckx_pkg::WORD_W-1:0]  word_in_block;

    ckx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ckx_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_data_in       (s_axis_tdata[63:0]),
        .i_xor_enable    (s_axis_tdata[64]),
        .i_out_ready     (m_axis_tready),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (m_axis_tvalid),
        .o_data_out      (data_out),
        .o_word_in_block (word_in_block)
    );

    assign m_axis_tdata = {5'b0, word_in_block, data_out};

endmodule

`default_nettype wire
